// ----- src/orl_pkg.sv -----
// Shared types, codes and sizing for the ordered record list.
package orl_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 5;
   // compare width: holds count + 2 and any position without wrap
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_POS   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   typedef struct packed {
      logic [30:0] key;
      logic [63:0] name_low;
      logic [7:0]  name_high;
   } rec_type;

endpackage

// ----- src/ordered_record_list_unit.sv -----
// Top level of the ordered record list: sequencer, record memory, result register.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  cmd, position, match_key, new_key, name
//   rsp_     out        rsp_valid / rsp_ready  status, record key/name, entry_count
//
// One item at a time. All list work goes through a single record memory port
// pair (one read, one write a cycle, read data registered) and one key comparator.
// Each entry visited takes a read state, then a compare/write state. Per item:
// accept, decode, a read and an eval step per entry visited, (insert: a put step
// to place), then a finish step to hand off; errors go from decode to the hand-off.
// Reset (synchronous) empties the list; the record memory itself is not cleared.
// A waiting result sits in the rsp_ register; the next item is taken meanwhile and
// only its hand-off stalls until rsp_ready frees the register.
module ordered_record_list_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_position,
   input  logic [30:0] req_match_key,
   input  logic [30:0] req_new_key,
   input  logic [63:0] req_new_name_low,
   input  logic [7:0]  req_new_name_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [30:0] rsp_record_key,
   output logic [63:0] rsp_record_name_low,
   output logic [7:0]  rsp_record_name_high,
   output logic [4:0]  rsp_entry_count
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_READ   = 6'b000100,
      S_EVAL   = 6'b001000,
      S_PUT    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   localparam int IDX_W = orl_pkg::IDX_W;
   localparam int CNT_W = orl_pkg::CNT_W;
   localparam int CMP_W = orl_pkg::CMP_W;

   // state and captured item
   state_type              state_ff, state_in;
   orl_pkg::cmd_type       cmd_ff, cmd_in;
   logic [4:0]             pos_ff, pos_in;
   logic [30:0]            mkey_ff, mkey_in;
   orl_pkg::rec_type       new_rec_ff, new_rec_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   shift_ff, shift_in;
   logic                   hit_ff, hit_in;
   orl_pkg::status_type    res_status_ff, res_status_in;
   orl_pkg::rec_type       res_rec_ff, res_rec_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   orl_pkg::status_type    rsp_status_ff, rsp_status_in;
   orl_pkg::rec_type       rsp_rec_ff, rsp_rec_in;
   logic [4:0]             rsp_count_ff, rsp_count_in;

   // record memory
   orl_pkg::rec_type       mem [orl_pkg::CAPACITY];
   orl_pkg::rec_type       rd_data_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [IDX_W-1:0]       mem_raddr;
   orl_pkg::rec_type       mem_wdata;

   // shared compare/step values
   logic [CMP_W-1:0]       pos_x, cnt_x, idx_x, idx_dn, idx_up, idx_up2, pos_dn;
   logic                   key_hit;

   assign pos_x   = CMP_W'(pos_ff);
   assign cnt_x   = CMP_W'(count_ff);
   assign idx_x   = CMP_W'(idx_ff);
   assign idx_dn  = idx_x - CMP_W'(1);
   assign idx_up  = idx_x + CMP_W'(1);
   assign idx_up2 = idx_x + CMP_W'(2);
   assign pos_dn  = pos_x - CMP_W'(1);
   assign key_hit = (rd_data_ff.key == mkey_ff);

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_record_key       = rsp_rec_ff.key;
   assign rsp_record_name_low  = rsp_rec_ff.name_low;
   assign rsp_record_name_high = rsp_rec_ff.name_high;
   assign rsp_entry_count      = rsp_count_ff;

   // read address: insert shifts pull from below, delete shifts from above
   always_comb begin
      if (cmd_ff == orl_pkg::CMD_INSERT) begin
         mem_raddr = idx_dn[IDX_W-1:0];
      end else if (cmd_ff == orl_pkg::CMD_DELETE && shift_ff) begin
         mem_raddr = idx_up[IDX_W-1:0];
      end else begin
         mem_raddr = idx_x[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      mkey_in       = mkey_ff;
      new_rec_in    = new_rec_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      shift_in      = shift_ff;
      hit_in        = hit_ff;
      res_status_in = res_status_ff;
      res_rec_in    = res_rec_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_x[IDX_W-1:0];
      mem_wdata     = rd_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in               = orl_pkg::cmd_type'(req_cmd);
               pos_in               = req_position;
               mkey_in              = req_match_key;
               new_rec_in.key       = req_new_key;
               new_rec_in.name_low  = req_new_name_low;
               new_rec_in.name_high = req_new_name_high;
               state_in             = S_DECODE;
            end
         end

         S_DECODE: begin
            res_status_in = orl_pkg::ST_OK;
            res_rec_in    = '0;
            hit_in        = 1'b0;
            shift_in      = 1'b0;
            idx_in        = '0;
            case (cmd_ff) inside
               orl_pkg::CMD_INSERT: begin
                  if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                     res_status_in = orl_pkg::ST_BAD_POS;
                     state_in      = S_FINISH;
                  end else if (cnt_x == CMP_W'(orl_pkg::CAPACITY)) begin
                     res_status_in = orl_pkg::ST_FULL;
                     state_in      = S_FINISH;
                  end else begin
                     // shift from the tail down to the insert slot
                     idx_in   = count_ff;
                     state_in = (cnt_x >= pos_x) ? S_READ : S_PUT;
                  end
               end
               orl_pkg::CMD_DELETE, orl_pkg::CMD_UPDATE: begin
                  if (count_ff == '0) begin
                     res_status_in = orl_pkg::ST_NOT_FOUND;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_READ;
                  end
               end
               default: begin
                  if (pos_x >= cnt_x) begin
                     res_status_in = orl_pkg::ST_RANGE;
                     state_in      = S_FINISH;
                  end else begin
                     idx_in   = pos_x[CNT_W-1:0];
                     state_in = S_READ;
                  end
               end
            endcase
         end

         S_READ: begin
            state_in = S_EVAL;
         end

         S_EVAL: begin
            case (cmd_ff)
               orl_pkg::CMD_INSERT: begin
                  mem_we   = 1'b1;
                  idx_in   = idx_dn[CNT_W-1:0];
                  state_in = (idx_dn >= pos_x) ? S_READ : S_PUT;
               end
               orl_pkg::CMD_DELETE: begin
                  if (shift_ff) begin
                     mem_we = 1'b1;
                     idx_in = idx_up[CNT_W-1:0];
                     if (idx_up2 < cnt_x) begin
                        state_in = S_READ;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = S_FINISH;
                     end
                  end else if (key_hit) begin
                     res_rec_in = rd_data_ff;
                     if (idx_up < cnt_x) begin
                        shift_in = 1'b1;
                        state_in = S_READ;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = S_FINISH;
                     end
                  end else begin
                     idx_in = idx_up[CNT_W-1:0];
                     if (idx_up < cnt_x) begin
                        state_in = S_READ;
                     end else begin
                        res_status_in = orl_pkg::ST_NOT_FOUND;
                        state_in      = S_FINISH;
                     end
                  end
               end
               orl_pkg::CMD_UPDATE: begin
                  if (key_hit) begin
                     mem_we    = 1'b1;
                     mem_wdata = new_rec_ff;
                     hit_in    = 1'b1;
                  end
                  idx_in = idx_up[CNT_W-1:0];
                  if (idx_up < cnt_x) begin
                     state_in = S_READ;
                  end else begin
                     if (hit_ff || key_hit) begin
                        res_rec_in = new_rec_ff;
                     end else begin
                        res_status_in = orl_pkg::ST_NOT_FOUND;
                     end
                     state_in = S_FINISH;
                  end
               end
               default: begin
                  res_rec_in = rd_data_ff;
                  state_in   = S_FINISH;
               end
            endcase
         end

         S_PUT: begin
            mem_we     = 1'b1;
            mem_waddr  = pos_dn[IDX_W-1:0];
            mem_wdata  = new_rec_ff;
            count_in   = count_ff + CNT_W'(1);
            res_rec_in = new_rec_ff;
            state_in   = S_FINISH;
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rec_in    = res_rec_ff;
               rsp_count_in  = 5'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_ff     <= shift_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      mkey_ff       <= mkey_in;
      new_rec_ff    <= new_rec_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_rec_ff    <= res_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule

// ----- src/orl_checker.sv -----
// Port-level checks for the ordered record list, bound to the top level.
module orl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [30:0] rsp_record_key,
   input logic [63:0] rsp_record_name_low,
   input logic [7:0]  rsp_record_name_high,
   input logic [4:0]  rsp_entry_count
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_record_key) && $stable(rsp_entry_count))
      else $error("stalled result changed");

   // nothing pending right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // failed commands carry an all-zero record
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != orl_pkg::ST_OK |-> rsp_record_key == '0
         && rsp_record_name_low == '0 && rsp_record_name_high == '0)
      else $error("failed command shows a record");

   // one item in flight: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

endmodule

bind ordered_record_list_unit orl_checker u_orl_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the ordered record list unit.
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_ITEMS  = 1850;
   localparam int IDLE_LIMIT    = 2000;   // cycles with no item moved on either side
   localparam int DRAIN_CYCLES  = 40;     // worst item: a full scan of the list
   localparam int LONG_HOLD     = 300;    // receiver hold-off that fills the block
   localparam int MAX_REPORTS   = 10;
   localparam logic [30:0] KEY_MAX = 31'h7FFF_FFFF;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_type;

   typedef struct {
      orl_pkg::cmd_type  cmd;
      logic [4:0]        position;
      logic [30:0]       match_key;
      orl_pkg::rec_type  rec;
   } list_command_type;

   typedef struct {
      orl_pkg::status_type  status;
      orl_pkg::rec_type     rec;
      logic [4:0]           count;
   } list_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [4:0]  req_position;
   logic [30:0] req_match_key;
   logic [30:0] req_new_key;
   logic [63:0] req_new_name_low;
   logic [7:0]  req_new_name_high;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [30:0] rsp_record_key;
   logic [63:0] rsp_record_name_low;
   logic [7:0]  rsp_record_name_high;
   logic [4:0]  rsp_entry_count;

   ordered_record_list_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_position         (req_position),
      .req_match_key        (req_match_key),
      .req_new_key          (req_new_key),
      .req_new_name_low     (req_new_name_low),
      .req_new_name_high    (req_new_name_high),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_record_key       (rsp_record_key),
      .rsp_record_name_low  (rsp_record_name_low),
      .rsp_record_name_high (rsp_record_name_high),
      .rsp_entry_count      (rsp_entry_count)
   );

   always #6 clock = ~clock;

   // Predicted list contents, updated as each item is accepted.
   orl_pkg::rec_type list_rec [orl_pkg::CAPACITY];
   int               list_count = 0;
   list_result_type  expected_results [$];
   logic [30:0]      key_pool [8];

   int fail_count    = 0;
   int idle_cycles   = 0;
   int hold_request  = 0;
   bit sender_fast   = 1'b0;
   bit receiver_fast = 1'b0;

   // ------------------------------------------------------------------
   // List predictor
   // ------------------------------------------------------------------
   function automatic list_result_type predict_command(input list_command_type c);
      list_result_type r;
      int slot;
      int hit;
      int pos;
      r.status = orl_pkg::ST_OK;
      r.rec    = '0;
      pos      = int'(c.position);
      case (c.cmd)
         orl_pkg::CMD_INSERT: begin
            // position check comes before the full check
            if (pos < 1 || pos > list_count + 1) begin
               r.status = orl_pkg::ST_BAD_POS;
            end else if (list_count >= orl_pkg::CAPACITY) begin
               r.status = orl_pkg::ST_FULL;
            end else begin
               for (slot = list_count; slot >= pos; slot--)
                  list_rec[slot] = list_rec[slot - 1];
               list_rec[pos - 1] = c.rec;
               list_count++;
               r.rec = c.rec;
            end
         end
         orl_pkg::CMD_DELETE: begin
            hit = -1;
            for (slot = 0; slot < list_count; slot++)
               if (hit < 0 && list_rec[slot].key == c.match_key) hit = slot;
            if (hit < 0) begin
               r.status = orl_pkg::ST_NOT_FOUND;
            end else begin
               r.rec = list_rec[hit];
               for (slot = hit; slot + 1 < list_count; slot++)
                  list_rec[slot] = list_rec[slot + 1];
               list_count--;
            end
         end
         orl_pkg::CMD_UPDATE: begin
            // every record that matched before the command is replaced
            hit = 0;
            for (slot = 0; slot < list_count; slot++) begin
               if (list_rec[slot].key == c.match_key) begin
                  list_rec[slot] = c.rec;
                  hit = 1;
               end
            end
            if (hit != 0) r.rec = c.rec;
            else r.status = orl_pkg::ST_NOT_FOUND;
         end
         default: begin
            if (pos >= list_count) r.status = orl_pkg::ST_RANGE;
            else r.rec = list_rec[pos];
         end
      endcase
      r.count = 5'(list_count);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Item construction
   // ------------------------------------------------------------------
   function automatic list_command_type build_command(input orl_pkg::cmd_type cmd,
                                                      input int pos,
                                                      input logic [30:0] mkey,
                                                      input logic [30:0] nkey,
                                                      input logic [63:0] nlo,
                                                      input logic [7:0] nhi);
      list_command_type c;
      c.cmd            = cmd;
      c.position       = 5'(pos);
      c.match_key      = mkey;
      c.rec.key        = nkey;
      c.rec.name_low   = nlo;
      c.rec.name_high  = nhi;
      return c;
   endfunction

   // Small pool keeps duplicate keys common, so multi-record updates happen.
   function automatic logic [30:0] random_key();
      if ($urandom_range(0, 7) < 4) return key_pool[$urandom_range(0, 7)];
      return 31'($urandom);
   endfunction

   function automatic logic [63:0] random_name_low();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [30:0] present_or_random_key();
      if (list_count > 0 && $urandom_range(0, 99) < 80)
         return list_rec[$urandom_range(0, list_count - 1)].key;
      return random_key();
   endfunction

   function automatic int noise_position();
      if ($urandom_range(0, 19) == 0) return int'($urandom_range(0, 31));
      return int'($urandom_range(0, 16));
   endfunction

   function automatic list_command_type random_command(input traffic_mode_type mode);
      list_command_type c;
      int  r;
      int  top;
      bit  noise;
      orl_pkg::cmd_type cmd;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_GROW:   cmd = (r < 60) ? orl_pkg::CMD_INSERT :
                            (r < 70) ? orl_pkg::CMD_DELETE :
                            (r < 80) ? orl_pkg::CMD_UPDATE : orl_pkg::CMD_READ;
         MODE_SHRINK: cmd = (r < 15) ? orl_pkg::CMD_INSERT :
                            (r < 70) ? orl_pkg::CMD_DELETE :
                            (r < 80) ? orl_pkg::CMD_UPDATE : orl_pkg::CMD_READ;
         default:     cmd = (r < 30) ? orl_pkg::CMD_INSERT :
                            (r < 55) ? orl_pkg::CMD_DELETE :
                            (r < 75) ? orl_pkg::CMD_UPDATE : orl_pkg::CMD_READ;
      endcase
      noise = ($urandom_range(0, 99) < 12);
      c = build_command(cmd, 0, random_key(), random_key(), random_name_low(),
                        8'($urandom_range(0, 255)));
      case (cmd)
         orl_pkg::CMD_INSERT: begin
            top = (list_count + 1 > 16) ? 16 : list_count + 1;
            c.position = noise ? 5'(noise_position()) : 5'($urandom_range(1, top));
         end
         orl_pkg::CMD_DELETE, orl_pkg::CMD_UPDATE: begin
            c.position = 5'($urandom_range(0, 31));
            if (!noise) c.match_key = present_or_random_key();
         end
         default: begin
            if (noise || list_count == 0) c.position = 5'(noise_position());
            else c.position = 5'($urandom_range(0, list_count - 1));
         end
      endcase
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Sender: random gap, then hold the item until the block takes it
   // ------------------------------------------------------------------
   task automatic send_item(input list_command_type c);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= c.cmd;
      req_position      <= c.position;
      req_match_key     <= c.match_key;
      req_new_key       <= c.rec.key;
      req_new_name_low  <= c.rec.name_low;
      req_new_name_high <= c.rec.name_high;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_command(c));
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall per result, plus an optional long hold-off
   // ------------------------------------------------------------------
   initial begin : receiver
      int low_cycles;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         low_cycles = receiver_fast ? 0 : $urandom_range(0, 13);
         if (hold_request > 0) begin
            low_cycles   = low_cycles + hold_request;
            hold_request = 0;
         end
         if (low_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (low_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : result_checker
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            note_failure($sformatf(
               "result with nothing expected: status %0d key %h count %0d",
               rsp_status, rsp_record_key, rsp_entry_count));
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status || rsp_record_key !== want.rec.key ||
                rsp_record_name_low !== want.rec.name_low ||
                rsp_record_name_high !== want.rec.name_high ||
                rsp_entry_count !== want.count)
               note_failure($sformatf(
                  {"mismatch: expected st %0d key %h name %h_%h cnt %0d,",
                   " got st %0d key %h name %h_%h cnt %0d"},
                  want.status, want.rec.key, want.rec.name_high, want.rec.name_low,
                  want.count, rsp_status, rsp_record_key, rsp_record_name_high,
                  rsp_record_name_low, rsp_entry_count));
         end
      end
   end

   // Watchdog: ends the run when no item moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Errors on an empty list, edge positions, extreme fields, multi-record update.
   task automatic test_directed();
      send_item(build_command(orl_pkg::CMD_READ,   0, '0, '0, '0, '0));     // empty read
      send_item(build_command(orl_pkg::CMD_DELETE, 0, '0, '0, '0, '0));     // empty delete
      send_item(build_command(orl_pkg::CMD_UPDATE, 0, '0, KEY_MAX, '1, '1)); // empty update
      send_item(build_command(orl_pkg::CMD_INSERT, 0, '0, 31'd5, '1, '1));  // position zero
      send_item(build_command(orl_pkg::CMD_INSERT, 2, '0, 31'd5, '1, '1));  // past the end
      send_item(build_command(orl_pkg::CMD_INSERT, 1, KEY_MAX, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_INSERT, 2, '0, KEY_MAX, '1, 8'hFF)); // append
      send_item(build_command(orl_pkg::CMD_INSERT, 1, '0, 31'h5555_5555,
                              64'hAAAA_AAAA_AAAA_AAAA, 8'h5A));             // front
      send_item(build_command(orl_pkg::CMD_INSERT, 2, '0, 31'h2AAA_AAAA,
                              64'h5555_5555_5555_5555, 8'hA5));             // middle
      send_item(build_command(orl_pkg::CMD_INSERT, 31, '0, 31'd9, '1, '1)); // far past end
      send_item(build_command(orl_pkg::CMD_READ,   0, '0, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_READ,   3, '0, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_READ,   4, '0, '0, '0, '0));     // out of range
      send_item(build_command(orl_pkg::CMD_READ,  16, '0, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_READ,  31, '0, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_INSERT, 5, '0, '0,
                              64'h0123_4567_89AB_CDEF, 8'h3C));
      send_item(build_command(orl_pkg::CMD_UPDATE, 0, '0, 31'h0123_4567,
                              64'hFEDC_BA98_7654_3210, 8'hC3));             // two matches
      send_item(build_command(orl_pkg::CMD_READ,   4, '0, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_DELETE, 0, '0, '0, '0, '0));     // key gone
      send_item(build_command(orl_pkg::CMD_DELETE, 0, KEY_MAX, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_DELETE, 0, 31'h0123_4567,
                              '0, '0, '0));                                 // first of two
      send_item(build_command(orl_pkg::CMD_READ,   2, '0, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_UPDATE, 0, 31'h5555_5555, KEY_MAX, '1, 8'hFF));
      send_item(build_command(orl_pkg::CMD_READ,   3, '0, '0, '0, '0));
   endtask

   // Fill to capacity, probe the full list, then empty it again.
   task automatic test_full_list();
      while (list_count < orl_pkg::CAPACITY)
         send_item(build_command(orl_pkg::CMD_INSERT, $urandom_range(1, list_count + 1),
                                 '0, random_key(), random_name_low(), 8'($urandom)));
      send_item(build_command(orl_pkg::CMD_INSERT, 16, '0, 31'd1, '1, '1)); // full
      send_item(build_command(orl_pkg::CMD_INSERT, $urandom_range(1, 15), '0, 31'd1,
                              '1, '1));
      send_item(build_command(orl_pkg::CMD_INSERT, 0, '0, 31'd1, '1, '1));  // bad beats full
      send_item(build_command(orl_pkg::CMD_READ,  15, '0, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_READ,  16, '0, '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_UPDATE, 0, list_rec[15].key, random_key(),
                              random_name_low(), 8'($urandom)));
      while (list_count > 0)
         send_item(build_command(orl_pkg::CMD_DELETE, 0,
                                 list_rec[$urandom_range(0, list_count - 1)].key,
                                 '0, '0, '0));
      send_item(build_command(orl_pkg::CMD_DELETE, 0, random_key(), '0, '0, '0));
   endtask

   // Receiver stops for a long stretch while items keep coming back to back.
   task automatic test_result_backpressure();
      hold_request = LONG_HOLD;
      sender_fast  = 1'b1;
      repeat (30) send_item(random_command(MODE_GROW));
      sender_fast  = 1'b0;
   endtask

   // Phases of growing, shrinking and mixed traffic with random pacing.
   task automatic test_random_traffic();
      int sent;
      int phase_len;
      traffic_mode_type mode;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       mode = MODE_GROW;
            1:       mode = MODE_SHRINK;
            default: mode = MODE_MIXED;
         endcase
         // near a full list, a grow phase turns into a shrink phase half the time
         if (list_count >= orl_pkg::CAPACITY - 1 && mode == MODE_GROW &&
             $urandom_range(0, 1) == 0)
            mode = MODE_SHRINK;
         phase_len     = $urandom_range(20, 80);
         sender_fast   = ($urandom_range(0, 3) == 0);
         receiver_fast = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            send_item(random_command(mode));
            sent++;
         end
      end
      sender_fast   = 1'b0;
      receiver_fast = 1'b0;
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_cmd           <= orl_pkg::CMD_INSERT;
      req_position      <= '0;
      req_match_key     <= '0;
      req_new_key       <= '0;
      req_new_name_low  <= '0;
      req_new_name_high <= '0;
      key_pool[0] = '0;
      key_pool[1] = KEY_MAX;
      for (int k = 2; k < 8; k++) key_pool[k] = 31'($urandom);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_list();
      test_result_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
